// ===== src/scacs_pkg.sv =====
// Shared constants and types for the sine/cosine approximator.
// Depends on nothing; every other file imports it.
package scacs_pkg;

   // Field formats
   localparam int ANGLE_W          = 32;
   localparam int VALUE_W          = 32;
   localparam int ANGLE_FRAC_BITS  = 26;
   localparam int RESULT_FRAC_BITS = 30;

   // Command codes
   localparam logic CMD_SINE   = 1'b0;
   localparam logic CMD_COSINE = 1'b1;

   // Working formats: angle widened to Q32, polynomial in Q30
   localparam int ANGLE_SHIFT = 32 - ANGLE_FRAC_BITS;
   localparam int X_W         = ANGLE_W + ANGLE_SHIFT + 1;
   localparam int XQ_W        = X_W - 8;
   localparam int PROD_W      = XQ_W + 24;
   localparam int K_W         = PROD_W - 48;
   localparam int KP_W        = K_W + 35;
   localparam int R_W         = KP_W + 1;
   localparam int R30_W       = 33;
   localparam int SQ_W        = 2 * R30_W;
   localparam int Y_W         = 34;
   localparam int T5_W        = Y_W + 25;
   localparam int T_W         = 30;
   localparam int TP_W        = 64;
   localparam int T2_W        = 34;
   localparam int VP_W        = 64;
   localparam int V_W         = 34;
   localparam int OUT_SHIFT   = 30 - RESULT_FRAC_BITS;

   localparam logic signed [35:0] HALF_PI_Q32 = 36'sh1921FB544;
   localparam logic signed [35:0] PI_Q32      = 36'sh3243F6A89;
   localparam logic signed [24:0] INV_PI_Q24  = 25'sh0517CC2;
   localparam logic signed [24:0] COEF5_Q30   = 25'sd7894653;
   localparam logic signed [31:0] COEF3_Q30   = 32'sd177477835;
   localparam logic signed [31:0] COEF1_Q30   = 32'sd1073411097;
   localparam logic signed [V_W-1:0] ONE_Q30  = V_W'(64'sd1073741824);
   localparam logic signed [V_W-1:0] ROUND_OUT = V_W'((64'sd1 <<< OUT_SHIFT) >>> 1);

   localparam logic signed [VALUE_W-1:0] VALUE_MAX =
      VALUE_W'(64'sd1 <<< RESULT_FRAC_BITS);
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = -VALUE_MAX;

   // Reduced angle handed from range reduction to the polynomial
   typedef struct packed {
      logic signed [R30_W-1:0] r30;
      logic                    k_odd;
   } reduced_type;

endpackage

// ===== src/scacs_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on scacs_pkg.
interface scacs_req_if;
   import scacs_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [ANGLE_W-1:0]  angle;
   logic                       command;
   modport source (output valid, angle, command, input ready);
   modport sink   (input valid, angle, command, output ready);
endinterface

interface scacs_rsp_if;
   import scacs_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  value;
   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

// ===== src/scacs_reduce.sv =====
// Range reduction: angle -> r = x - k*pi in Q30 and the parity of k.
// Five register stages; depends on scacs_pkg.
module scacs_reduce (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [scacs_pkg::ANGLE_W-1:0] angle,
   input  logic                           command,
   output logic                           out_valid,
   input  logic                           out_ready,
   output scacs_pkg::reduced_type         out_data
);
   import scacs_pkg::*;

   localparam int NSTAGE = 5;

   logic [NSTAGE-1:0] vld_ff, vld_in, vld_prev;
   logic [NSTAGE:0]   en;

   logic signed [X_W-1:0]    x1_ff, x1_in, x2_ff, x3_ff, x4_ff;
   logic signed [X_W-1:0]    xq_sum;
   logic signed [XQ_W-1:0]   xq;
   logic signed [PROD_W-1:0] prod_ff, prod_in, prod_sum;
   logic signed [K_W-1:0]    k3_ff, k3_in, k4_ff;
   logic signed [KP_W-1:0]   kp_ff, kp_in;
   logic signed [R_W-1:0]    r_sum;
   reduced_type              red_ff, red_in;

   // stage i loads when empty or when its content moves on
   always_comb begin
      en[NSTAGE] = out_ready;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_prev = {vld_ff[NSTAGE-2:0], in_valid};
      for (int i = 0; i < NSTAGE; i++) begin
         if (en[i]) begin
            vld_in[i] = vld_prev[i];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // datapath
   always_comb begin
      x1_in = X_W'(angle) <<< ANGLE_SHIFT;
      if (command == CMD_COSINE) begin
         x1_in = x1_in + X_W'(HALF_PI_Q32);
      end
      xq_sum   = x1_ff + X_W'(128);
      xq       = xq_sum[X_W-1:8];
      prod_in  = PROD_W'(xq) * PROD_W'(INV_PI_Q24);
      prod_sum = prod_ff + (PROD_W'(1) <<< 47);
      k3_in    = prod_sum[PROD_W-1:48];
      kp_in    = KP_W'(k3_ff) * KP_W'(PI_Q32);
      r_sum    = R_W'(x4_ff) - R_W'(kp_ff) + R_W'(2);
      red_in.r30   = r_sum[R30_W+1:2];
      red_in.k_odd = k4_ff[0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x1_ff <= x1_in;
      end
      if (en[1]) begin
         x2_ff   <= x1_ff;
         prod_ff <= prod_in;
      end
      if (en[2]) begin
         x3_ff <= x2_ff;
         k3_ff <= k3_in;
      end
      if (en[3]) begin
         x4_ff <= x3_ff;
         k4_ff <= k3_ff;
         kp_ff <= kp_in;
      end
      if (en[4]) begin
         red_ff <= red_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NSTAGE-1];
   assign out_data  = red_ff;

endmodule

// ===== src/scacs_poly.sv =====
// Odd polynomial r*((c5*r^2 - c3)*r^2 + c1), sign fix and saturation.
// Five register stages, the last is the output register; depends on scacs_pkg.
module scacs_poly (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  scacs_pkg::reduced_type               in_data,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [scacs_pkg::VALUE_W-1:0] value
);
   import scacs_pkg::*;

   localparam int NSTAGE = 5;

   logic [NSTAGE-1:0] vld_ff, vld_in, vld_prev;
   logic [NSTAGE:0]   en;

   logic signed [SQ_W-1:0]  sq_ff, sq_in, sq_sum;
   logic signed [Y_W-1:0]   y_in, y2_ff;
   logic signed [T5_W-1:0]  t5_ff, t5_in, t5_sum;
   logic signed [T_W-1:0]   t_val;
   logic signed [TP_W-1:0]  tp_ff, tp_in, tp_sum;
   logic signed [T2_W-1:0]  t2_val;
   logic signed [VP_W-1:0]  vp_ff, vp_in, vp_sum;
   logic signed [V_W-1:0]   v_raw, v_sat, v_rnd;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   reduced_type             red1_ff, red2_ff, red3_ff;
   logic                    odd4_ff;

   always_comb begin
      en[NSTAGE] = out_ready;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_prev = {vld_ff[NSTAGE-2:0], in_valid};
      for (int i = 0; i < NSTAGE; i++) begin
         if (en[i]) begin
            vld_in[i] = vld_prev[i];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // every product is rounded half-up back to Q30 in the following stage
   always_comb begin
      sq_in  = SQ_W'(in_data.r30) * SQ_W'(in_data.r30);
      sq_sum = sq_ff + (SQ_W'(1) <<< 29);
      y_in   = sq_sum[Y_W+29:30];
      t5_in  = T5_W'(COEF5_Q30) * T5_W'(y_in);
      t5_sum = t5_ff + (T5_W'(1) <<< 29);
      t_val  = T_W'(t5_sum[T5_W-1:30]) - T_W'(COEF3_Q30);
      tp_in  = TP_W'(t_val) * TP_W'(y2_ff);
      tp_sum = tp_ff + (TP_W'(1) <<< 29);
      t2_val = tp_sum[TP_W-1:30] + T2_W'(COEF1_Q30);
      vp_in  = VP_W'(red3_ff.r30) * VP_W'(t2_val);
      vp_sum = vp_ff + (VP_W'(1) <<< 29);
      v_raw  = vp_sum[VP_W-1:30];
      if (odd4_ff) begin
         v_raw = -v_raw;
      end
      if (v_raw > ONE_Q30) begin
         v_sat = ONE_Q30;
      end else if (v_raw < -ONE_Q30) begin
         v_sat = -ONE_Q30;
      end else begin
         v_sat = v_raw;
      end
      // saturated value is within +-1, so the narrowed result stays in range
      v_rnd    = (v_sat + ROUND_OUT) >>> OUT_SHIFT;
      value_in = v_rnd[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sq_ff   <= sq_in;
         red1_ff <= in_data;
      end
      if (en[1]) begin
         t5_ff   <= t5_in;
         y2_ff   <= y_in;
         red2_ff <= red1_ff;
      end
      if (en[2]) begin
         tp_ff   <= tp_in;
         red3_ff <= red2_ff;
      end
      if (en[3]) begin
         vp_ff   <= vp_in;
         odd4_ff <= red3_ff.k_odd;
      end
      if (en[4]) begin
         value_ff <= value_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NSTAGE-1];
   assign value     = value_ff;

endmodule

// ===== src/sine_cosine_approximator.sv =====
// Sine/cosine approximator. Takes a Q5.26 angle in radians and a command
// (sine or cosine) on req_chan and returns the Q1.30 result, saturated to
// plus or minus one, on rsp_chan. Cosine is sine of the angle plus pi/2;
// the angle is reduced by the nearest multiple of pi and a fifth-order odd
// polynomial is evaluated. One angle is taken every clock unless backpressure
// has stalled the first stage; a request passes through ten register stages
// around the chain of six dependent multiplications (1/pi, k*pi, r^2, the two
// polynomial terms and the final one), each in a register stage of its own.
// Backpressure stalls only the stages that hold data, so empty stages keep
// accepting while a result waits.
// Depends on scacs_pkg, scacs_if, scacs_reduce and scacs_poly.
module sine_cosine_approximator (
   input logic         clock,
   input logic         reset,
   scacs_req_if.sink   req_chan,
   scacs_rsp_if.source rsp_chan
);
   import scacs_pkg::*;

   logic        red_valid;
   logic        red_ready;
   reduced_type red_data;

   scacs_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .angle     (req_chan.angle),
      .command   (req_chan.command),
      .out_valid (red_valid),
      .out_ready (red_ready),
      .out_data  (red_data)
   );

   scacs_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_data   (red_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .value     (rsp_chan.value)
   );

endmodule

// ===== src/scacs_checker.sv =====
// Port-level checks for the sine/cosine approximator, bound to the top level.
// Depends on scacs_pkg.
module scacs_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [scacs_pkg::VALUE_W-1:0] rsp_value
);
   import scacs_pkg::*;

   // a waiting result is held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response dropped or changed while stalled");

   // results never exceed plus or minus one
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= VALUE_MAX) && (rsp_value >= VALUE_MIN))
      else $error("response outside +-1");

   // nothing comes out right after reset
   a_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sine_cosine_approximator scacs_checker u_scacs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.value)
);

// ===== bench/sincos_result_checker.sv =====
// Watches the request and response channels of the sine/cosine approximator,
// predicts each result in fixed point and compares it with what comes out.
// Depends on scacs_pkg and scacs_if.
module sincos_result_checker (
   input  logic        clock,
   input  logic        reset,
   scacs_req_if        req_mon,
   scacs_rsp_if        rsp_mon,
   output int          mismatches,
   output int          outstanding,
   output int          checked
);
   import scacs_pkg::*;

   // Q32 angles, Q24 reciprocal, Q30 polynomial coefficients
   localparam longint HALF_PI_FX = 64'sh1_921F_B544;
   localparam longint PI_FX      = 64'sh3_243F_6A89;
   localparam longint RECIP_PI   = 64'sh51_7CC2;
   localparam longint C5         = 64'sd7894653;
   localparam longint C3         = 64'sd177477835;
   localparam longint C1         = 64'sd1073411097;

   logic signed [VALUE_W-1:0] predicted_values[$];

   // round half up: add half an ulp, then floor
   function automatic longint round_down_by(longint v, int s);
      if (s == 0)
         return v;
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [VALUE_W-1:0] sincos_fixed(
      logic signed [ANGLE_W-1:0] angle, logic cmd);
      longint x, xq, k, r30, y, t, v, lim;
      x = longint'(angle) <<< (32 - ANGLE_FRAC_BITS);
      if (cmd == CMD_COSINE)
         x = x + HALF_PI_FX;
      xq = round_down_by(x, 8);
      k = round_down_by(xq * RECIP_PI, 48);
      r30 = round_down_by(x - k * PI_FX, 2);
      y = round_down_by(r30 * r30, 30);
      t = round_down_by(C5 * y, 30) - C3;
      t = round_down_by(t * y, 30) + C1;
      v = round_down_by(r30 * t, 30);
      if (k[0])
         v = -v;
      lim = longint'(1) <<< 30;
      if (v > lim)
         v = lim;
      if (v < -lim)
         v = -lim;
      v = round_down_by(v, 30 - RESULT_FRAC_BITS);
      lim = longint'(1) <<< RESULT_FRAC_BITS;
      if (v > lim)
         v = lim;
      if (v < -lim)
         v = -lim;
      return v[VALUE_W-1:0];
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
      checked     = 0;
   end

   always @(posedge clock) begin
      logic signed [VALUE_W-1:0] want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_values.size() == 0) begin
               $error("value: expected none, actual %0d", rsp_mon.value);
               mismatches <= mismatches + 1;
            end else begin
               want = predicted_values.pop_front();
               if (rsp_mon.value !== want) begin
                  $error("value: expected %0d, actual %0d", want, rsp_mon.value);
                  mismatches <= mismatches + 1;
               end
               checked <= checked + 1;
            end
         end
         if (req_mon.valid && req_mon.ready)
            predicted_values.push_back(sincos_fixed(req_mon.angle, req_mon.command));
         outstanding <= predicted_values.size();
      end
   end

endmodule

// ===== bench/sine_cosine_approximator_tb.sv =====
// Top of the sine/cosine approximator bench: clock, reset, angle stimulus and
// response backpressure; the verdict comes from sincos_result_checker.
// Depends on scacs_pkg, scacs_if, sincos_result_checker and the block itself.
module sine_cosine_approximator_tb;
   import scacs_pkg::*;

   localparam int     RANDOM_ANGLES = 1750;
   localparam int     CYCLE_LIMIT   = 1000000;
   localparam int     DRAIN_CYCLES  = 20;
   localparam longint HALF_PI_Q26   = 64'sd105414357;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   checked;
   int   cycles;
   int   angles_sent;
   int   cosines_sent;
   int   near_boundary;

   scacs_req_if req_chan ();
   scacs_rsp_if rsp_chan ();

   sine_cosine_approximator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sincos_result_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [ANGLE_W-1:0] pick_angle(output bit near);
      longint a;
      near = 1'b0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: a = longint'($urandom);
         4, 5, 6:    a = longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sh2000_0000;
         7, 8: begin
            // odd and even multiples of pi/2 bracket the rounding of k
            near = 1'b1;
            a = (longint'($urandom_range(0, 40)) - 20) * HALF_PI_Q26
                + longint'($urandom_range(0, 512)) - 256;
         end
         default: begin
            if ($urandom_range(0, 1))
               a = 64'sh8000_0000 + longint'($urandom_range(0, 255));
            else
               a = 64'sh7FFF_FFFF - longint'($urandom_range(0, 255));
         end
      endcase
      return a[ANGLE_W-1:0];
   endfunction

   // offer one angle after an optional gap, return at its transfer edge
   task automatic send_angle(logic signed [ANGLE_W-1:0] angle, logic cmd, int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.angle   <= angle;
      req_chan.command <= cmd;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      angles_sent++;
      if (cmd == CMD_COSINE)
         cosines_sent++;
   endtask

   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("sine_cosine_approximator_tb: FAIL");
         $finish;
      end
   end

   // response side: random stalls, long clean stretches, two long hold-offs
   initial begin
      bit first_hold;
      bit second_hold;
      int gap;
      first_hold  = 1'b0;
      second_hold = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if ((!first_hold && checked >= 200) || (!second_hold && checked >= 1200)) begin
            if (!first_hold)
               first_hold = 1'b1;
            else
               second_hold = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(50, 150)) @(posedge clock);
            else
               repeat ($urandom_range(1, 8)) @(posedge clock);
            gap = idle_cycles();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      logic signed [ANGLE_W-1:0] angle;
      bit near;
      int gap;
      cycles        = 0;
      angles_sent   = 0;
      cosines_sent  = 0;
      near_boundary = 0;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.angle   <= '0;
      req_chan.command <= CMD_SINE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // field extremes, zero, and angles next to multiples of pi/2
      send_angle(32'sh8000_0000, CMD_SINE, 0);
      send_angle(32'sh8000_0000, CMD_COSINE, 0);
      send_angle(32'sh7FFF_FFFF, CMD_SINE, 0);
      send_angle(32'sh7FFF_FFFF, CMD_COSINE, 0);
      send_angle(32'sh0000_0000, CMD_SINE, 1);
      send_angle(32'sh0000_0000, CMD_COSINE, 0);
      send_angle(32'sh0000_0001, CMD_SINE, 0);
      send_angle(-32'sh1, CMD_COSINE, 0);
      send_angle(32'(HALF_PI_Q26), CMD_SINE, 0);
      send_angle(32'(HALF_PI_Q26 + 1), CMD_SINE, 2);
      send_angle(32'(HALF_PI_Q26 - 1), CMD_SINE, 0);
      send_angle(32'(-HALF_PI_Q26), CMD_COSINE, 0);
      send_angle(32'(-HALF_PI_Q26 - 1), CMD_COSINE, 0);
      send_angle(32'(3 * HALF_PI_Q26), CMD_SINE, 0);
      send_angle(32'(-3 * HALF_PI_Q26 + 1), CMD_SINE, 0);
      send_angle(32'(2 * HALF_PI_Q26), CMD_SINE, 0);
      send_angle(32'(2 * HALF_PI_Q26), CMD_COSINE, 5);
      send_angle(32'(19 * HALF_PI_Q26), CMD_SINE, 0);
      send_angle(32'(-19 * HALF_PI_Q26), CMD_COSINE, 0);
      send_angle(32'(20 * HALF_PI_Q26), CMD_COSINE, 0);
      send_angle(32'sh5555_5555, CMD_SINE, 0);
      send_angle(32'shAAAA_AAAA, CMD_COSINE, 0);
      wait_all_results();

      for (int i = 0; i < RANDOM_ANGLES; i++) begin
         if (i == 900)
            wait_all_results();
         gap = (i % 400 < 80) ? 0 : idle_cycles();
         angle = pick_angle(near);
         if (near)
            near_boundary++;
         send_angle(angle, logic'($urandom_range(0, 1)), gap);
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d angles (%0d cosine, %0d next to multiples of pi/2)",
               angles_sent, cosines_sent, near_boundary);
      $display("%0d results compared, %0d mismatches", checked, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("sine_cosine_approximator_tb: PASS");
      else
         $display("sine_cosine_approximator_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/scacs_pkg.sv
src/scacs_if.sv
src/scacs_reduce.sv
src/scacs_poly.sv
src/sine_cosine_approximator.sv
src/scacs_checker.sv
bench/sincos_result_checker.sv
bench/sine_cosine_approximator_tb.sv
